// ===== rtl/jtt_pkg.sv =====
// Shared types, constants and action codes for the journal transaction tracker.
// No dependencies; used by every other file in rtl/ except jtt_ram.
package jtt_pkg;

  localparam int LOG_SLOTS = 30;
  localparam int OP_BUDGET = 10;

  localparam int CNT_W    = 5;
  localparam int BLK_W    = 32;
  localparam int KIND_W   = 2;
  localparam int ACT_W    = 4;
  localparam int IDX_W    = (LOG_SLOTS > 1) ? $clog2(LOG_SLOTS) : 1;
  localparam int NEED_W   = CNT_W + 1 + $clog2(OP_BUDGET + 1);
  localparam int OUT_DW   = 72;

  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  localparam logic [ACT_W-1:0] ACT_GRANTED   = 4'd0;
  localparam logic [ACT_W-1:0] ACT_WAIT      = 4'd1;
  localparam logic [ACT_W-1:0] ACT_NEW_PIN   = 4'd2;
  localparam logic [ACT_W-1:0] ACT_ABSORBED  = 4'd3;
  localparam logic [ACT_W-1:0] ACT_FULL      = 4'd4;
  localparam logic [ACT_W-1:0] ACT_NO_TXN    = 4'd5;
  localparam logic [ACT_W-1:0] ACT_END_DONE  = 4'd6;
  localparam logic [ACT_W-1:0] ACT_COPY      = 4'd7;
  localparam logic [ACT_W-1:0] ACT_HEADER    = 4'd8;
  localparam logic [ACT_W-1:0] ACT_INSTALL   = 4'd9;
  localparam logic [ACT_W-1:0] ACT_UNDERFLOW = 4'd10;

  typedef struct packed {
    logic             eq;
    logic [BLK_W-1:0] slot;
  } alu_res_t;

endpackage

// ===== rtl/journal_transaction_tracker_unit.sv =====
// Journal transaction tracker top level: sequencer, slot table RAM, output register.
// Depends on jtt_pkg, jtt_ram, jtt_alu.
//
// One input beat is taken at a time; s_tready is high only while the sequencer is idle.
// A begin, an end that does not commit, or any error answers with one result beat, which
// ST_ONE hands to the output register. A write to a non-empty table walks the slot table
// through the single RAM read port and shared comparator, one entry per cycle. A commit
// emits 2*entry_count + 2 result beats, one per cycle while m_tready is high. Invalid kind
// 3 is taken and dropped with no result. log_start may be written whenever the block is idle.
module journal_transaction_tracker_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [jtt_pkg::BLK_W-1:0]    cfg_wr_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [31:0]                  s_tdata,   // [31:0] block_number
  input  logic [1:0]                   s_tuser,   // [1:0] kind
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [jtt_pkg::OUT_DW-1:0]   m_tdata,   // [31:0] source_block, [63:32] target_block,
                                                  // [68:64] header_count, rest zero
  output logic [3:0]                   m_tuser,   // [3:0] action
  output logic                         m_tlast
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ONE    = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_COPY   = 3'd3;
  localparam logic [2:0] ST_HDR    = 3'd4;
  localparam logic [2:0] ST_INST   = 3'd5;
  localparam logic [2:0] ST_CLR    = 3'd6;

  logic [2:0]                    state, state_next;
  logic [jtt_pkg::CNT_W-1:0]     idx, idx_next;
  logic [jtt_pkg::CNT_W-1:0]     entry_count, entry_next;
  logic [jtt_pkg::CNT_W-1:0]     open_ops, open_next;
  logic [jtt_pkg::ACT_W-1:0]     one_act, one_act_next;
  logic [jtt_pkg::BLK_W-1:0]     log_start;
  logic [jtt_pkg::BLK_W-1:0]     blk;

  logic [jtt_pkg::ACT_W-1:0]     out_act;
  logic [jtt_pkg::BLK_W-1:0]     out_src, out_dst;
  logic [jtt_pkg::CNT_W-1:0]     out_cnt;
  logic                          out_last;

  logic                          emit, e_last;
  logic [jtt_pkg::ACT_W-1:0]     e_act;
  logic [jtt_pkg::BLK_W-1:0]     e_src, e_dst;
  logic [jtt_pkg::CNT_W-1:0]     e_cnt;

  logic                          out_free, accept;
  logic                          wr_en;
  logic [jtt_pkg::BLK_W-1:0]     wr_data, rd_data;
  logic [jtt_pkg::NEED_W-1:0]    need;
  logic [jtt_pkg::CNT_W:0]       open_p1;
  logic                          idx_at_end;
  jtt_pkg::alu_res_t             alu;

  assign s_tready = !rst && (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign wr_data  = (state == ST_IDLE) ? s_tdata : blk;

  assign open_p1    = {1'b0, open_ops} + (jtt_pkg::CNT_W + 1)'(1);
  assign need       = jtt_pkg::NEED_W'(entry_count)
                    + jtt_pkg::NEED_W'(open_p1) * jtt_pkg::NEED_W'(jtt_pkg::OP_BUDGET);
  assign idx_at_end = ((idx + jtt_pkg::CNT_W'(1)) == entry_count);

  jtt_ram #(
    .WIDTH (jtt_pkg::BLK_W),
    .DEPTH (jtt_pkg::LOG_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count[jtt_pkg::IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (idx_next[jtt_pkg::IDX_W-1:0]),
    .rd_data (rd_data)
  );

  jtt_alu u_alu (
    .cmp_a (rd_data),
    .cmp_b (blk),
    .base  (log_start),
    .idx   (idx),
    .res   (alu)
  );

  // rd_addr follows idx_next, so rd_data always holds table[idx]
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    entry_next   = entry_count;
    open_next    = open_ops;
    one_act_next = one_act;
    wr_en        = 1'b0;
    emit         = 1'b0;
    e_act        = one_act;
    e_src        = '0;
    e_dst        = '0;
    e_cnt        = '0;
    e_last       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          idx_next = '0;
          unique case (s_tuser)
            jtt_pkg::KIND_BEGIN: begin
              state_next = ST_ONE;
              if (need > jtt_pkg::NEED_W'(jtt_pkg::LOG_SLOTS)) begin
                one_act_next = jtt_pkg::ACT_WAIT;
              end else begin
                one_act_next = jtt_pkg::ACT_GRANTED;
                open_next    = open_ops + jtt_pkg::CNT_W'(1);
              end
            end
            jtt_pkg::KIND_WRITE: begin
              state_next = ST_ONE;
              if (entry_count >= jtt_pkg::CNT_W'(jtt_pkg::LOG_SLOTS)) begin
                one_act_next = jtt_pkg::ACT_FULL;
              end else if (open_ops == '0) begin
                one_act_next = jtt_pkg::ACT_NO_TXN;
              end else if (entry_count == '0) begin
                wr_en        = 1'b1;
                entry_next   = entry_count + jtt_pkg::CNT_W'(1);
                one_act_next = jtt_pkg::ACT_NEW_PIN;
              end else begin
                state_next = ST_SEARCH;
              end
            end
            jtt_pkg::KIND_END: begin
              if (open_ops == '0) begin
                state_next   = ST_ONE;
                one_act_next = jtt_pkg::ACT_UNDERFLOW;
              end else begin
                open_next = open_ops - jtt_pkg::CNT_W'(1);
                if (open_ops != jtt_pkg::CNT_W'(1) || entry_count == '0) begin
                  state_next   = ST_ONE;
                  one_act_next = jtt_pkg::ACT_END_DONE;
                end else begin
                  state_next = ST_COPY;
                end
              end
            end
            default: ;  // kind 3: dropped
          endcase
        end
      end
      ST_ONE: begin
        if (out_free) begin
          emit       = 1'b1;
          e_act      = one_act;
          e_last     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (alu.eq) begin
          one_act_next = jtt_pkg::ACT_ABSORBED;
          state_next   = ST_ONE;
        end else if (idx_at_end) begin
          wr_en        = 1'b1;
          entry_next   = entry_count + jtt_pkg::CNT_W'(1);
          one_act_next = jtt_pkg::ACT_NEW_PIN;
          state_next   = ST_ONE;
        end else begin
          idx_next = idx + jtt_pkg::CNT_W'(1);
        end
      end
      ST_COPY: begin
        if (out_free) begin
          emit  = 1'b1;
          e_act = jtt_pkg::ACT_COPY;
          e_src = rd_data;
          e_dst = alu.slot;
          if (idx_at_end) begin
            idx_next   = '0;
            state_next = ST_HDR;
          end else begin
            idx_next = idx + jtt_pkg::CNT_W'(1);
          end
        end
      end
      ST_HDR: begin
        if (out_free) begin
          emit       = 1'b1;
          e_act      = jtt_pkg::ACT_HEADER;
          e_dst      = log_start;
          e_cnt      = entry_count;
          state_next = ST_INST;
        end
      end
      ST_INST: begin
        if (out_free) begin
          emit  = 1'b1;
          e_act = jtt_pkg::ACT_INSTALL;
          e_src = alu.slot;
          e_dst = rd_data;
          if (idx_at_end) begin
            idx_next   = '0;
            state_next = ST_CLR;
          end else begin
            idx_next = idx + jtt_pkg::CNT_W'(1);
          end
        end
      end
      ST_CLR: begin
        if (out_free) begin
          emit       = 1'b1;
          e_act      = jtt_pkg::ACT_HEADER;
          e_dst      = log_start;
          e_last     = 1'b1;
          entry_next = '0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      entry_count <= '0;
      open_ops    <= '0;
      one_act     <= jtt_pkg::ACT_GRANTED;
      log_start   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      entry_count <= entry_next;
      open_ops    <= open_next;
      one_act     <= one_act_next;
      if (cfg_wr_en) begin
        log_start <= cfg_wr_data;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk <= s_tdata;
    end
    if (emit) begin
      out_act  <= e_act;
      out_src  <= e_src;
      out_dst  <= e_dst;
      out_cnt  <= e_cnt;
      out_last <= e_last;
    end
  end

  assign m_tdata = {(jtt_pkg::OUT_DW - 2 * jtt_pkg::BLK_W - jtt_pkg::CNT_W)'(0),
                    out_cnt, out_dst, out_src};
  assign m_tuser = out_act;
  assign m_tlast = out_last;

endmodule

// ===== rtl/jtt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jtt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/jtt_alu.sv =====
// Shared compare and slot-address unit used by the search and commit walks.
// Depends on jtt_pkg.
module jtt_alu (
  input  logic [jtt_pkg::BLK_W-1:0] cmp_a,
  input  logic [jtt_pkg::BLK_W-1:0] cmp_b,
  input  logic [jtt_pkg::BLK_W-1:0] base,
  input  logic [jtt_pkg::CNT_W-1:0] idx,
  output jtt_pkg::alu_res_t         res
);

  always_comb begin
    res.eq   = (cmp_a == cmp_b);
    // log slot i sits right after the header block, mod 2^32
    res.slot = base + jtt_pkg::BLK_W'(1) + jtt_pkg::BLK_W'(idx);
  end

endmodule

// ===== rtl/jtt_checker.sv =====
// Port-level checker for the journal transaction tracker, bound to the top level.
// Depends on jtt_pkg and journal_transaction_tracker_unit.
module jtt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [1:0]                 s_tuser,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [jtt_pkg::OUT_DW-1:0] m_tdata,
  input logic [3:0]                 m_tuser,
  input logic                       m_tlast
);

  // a real item keeps the sequencer busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready &&
     (s_tuser == jtt_pkg::KIND_BEGIN || s_tuser == jtt_pkg::KIND_WRITE ||
      s_tuser == jtt_pkg::KIND_END)) |=> !s_tready)
    else $error("s_tready stayed high after an accepted item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
    else $error("stalled result beat changed");

  a_action_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= jtt_pkg::ACT_UNDERFLOW))
    else $error("undefined action code");

  // only copy and install beats carry a source block
  a_src_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != jtt_pkg::ACT_COPY && m_tuser != jtt_pkg::ACT_INSTALL)
      |-> (m_tdata[31:0] == 32'd0))
    else $error("source block nonzero on a non-copy beat");

  // a copy or install beat never ends the run; the cleared header does
  a_copy_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == jtt_pkg::ACT_COPY || m_tuser == jtt_pkg::ACT_INSTALL))
      |-> !m_tlast)
    else $error("commit command flagged as last");

endmodule

bind journal_transaction_tracker_unit jtt_checker u_jtt_checker (.*);
